// ===== design/shabh_pkg.sv =====
// Shared constants, types and helper functions for the SHA-256 block hasher.
package shabh_pkg;

    // Controller states.
    typedef enum logic [1:0] {
        ST_GATHER,
        ST_ROUND,
        ST_FINAL
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       shift_in;    // take message word into the schedule window
        logic       load_vars;   // load working variables at block start
        logic       use_iv;      // chaining base is the initial hash
        logic       round_en;    // run one compression round
        logic [5:0] round_idx;   // round number for the constant table
        logic       final_add;   // add working variables into chaining words
        logic       load_out;    // capture the new chaining words as digest
        logic       out_shift;   // advance the digest buffer by one word
    } cmd_t;

    localparam int unsigned WORDS_PER_BLOCK = 16;
    localparam int unsigned HASH_WORDS      = 8;
    localparam int unsigned ROUNDS          = 64;

    localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned amt);
        return (v >> amt) | (v << (32 - amt));
    endfunction

    function automatic logic [31:0] sched_s0(input logic [31:0] v);
        return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] sched_s1(input logic [31:0] v);
        return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

    function automatic logic [31:0] round_s0(input logic [31:0] v);
        return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] round_s1(input logic [31:0] v);
        return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

endpackage

// ===== design/shabh_ctrl.sv =====
// Controller state machine: word gathering, round sequencing and digest output.
module shabh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              start_message,
    input  logic              end_message,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        word_index,
    output logic              last_word,
    output shabh_pkg::cmd_t   cmd
);

    shabh_pkg::state_t state_reg, state_next;
    logic [3:0] word_pos_reg, word_pos_next;
    logic [5:0] round_reg, round_next;
    logic       restart_reg, restart_next;
    logic       use_iv_reg, use_iv_next;
    logic       end_reg, end_next;
    logic       out_busy_reg, out_busy_next;
    logic [2:0] out_idx_reg, out_idx_next;
    logic       in_fire;
    logic       out_fire;

    assign in_ready   = (state_reg == shabh_pkg::ST_GATHER);
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_busy_reg;
    assign out_fire   = out_valid && out_ready;
    assign word_index = out_idx_reg;
    assign last_word  = (out_idx_reg == 3'd7);

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= shabh_pkg::ST_GATHER;
            word_pos_reg <= '0;
            round_reg    <= '0;
            restart_reg  <= 1'b1;
            use_iv_reg   <= 1'b0;
            end_reg      <= 1'b0;
            out_busy_reg <= 1'b0;
            out_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            word_pos_reg <= word_pos_next;
            round_reg    <= round_next;
            restart_reg  <= restart_next;
            use_iv_reg   <= use_iv_next;
            end_reg      <= end_next;
            out_busy_reg <= out_busy_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        word_pos_next = word_pos_reg;
        round_next    = round_reg;
        restart_next  = restart_reg;
        use_iv_next   = use_iv_reg;
        end_next      = end_reg;
        out_busy_next = out_busy_reg;
        out_idx_next  = out_idx_reg;

        cmd           = '0;
        cmd.use_iv    = use_iv_reg;
        cmd.round_idx = round_reg;

        // The digest buffer drains independently of the hashing work.
        if (out_fire)
        begin
            cmd.out_shift = 1'b1;
            out_idx_next  = out_idx_reg + 3'd1;
            if (out_idx_reg == 3'd7)
            begin
                out_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            shabh_pkg::ST_GATHER:
            begin
                if (in_fire)
                begin
                    cmd.shift_in  = 1'b1;
                    word_pos_next = word_pos_reg + 4'd1;
                    if (word_pos_reg == 4'd15)
                    begin
                        // Last word of the block: start compression.
                        use_iv_next   = restart_reg || start_message;
                        cmd.use_iv    = use_iv_next;
                        cmd.load_vars = 1'b1;
                        restart_next  = 1'b0;
                        end_next      = end_message;
                        round_next    = '0;
                        state_next    = shabh_pkg::ST_ROUND;
                    end
                    else if (start_message)
                    begin
                        restart_next = 1'b1;
                    end
                end
            end

            shabh_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = shabh_pkg::ST_FINAL;
                end
            end

            shabh_pkg::ST_FINAL:
            begin
                // A digest waits here until the previous one has drained.
                if (!(end_reg && out_busy_next))
                begin
                    cmd.final_add = 1'b1;
                    state_next    = shabh_pkg::ST_GATHER;
                    if (end_reg)
                    begin
                        cmd.load_out  = 1'b1;
                        out_busy_next = 1'b1;
                        out_idx_next  = '0;
                        restart_next  = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = shabh_pkg::ST_GATHER;
            end
        endcase
    end

endmodule

// ===== design/shabh_datapath.sv =====
// Datapath: message schedule window, round logic, chaining words and digest buffer.
module shabh_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  shabh_pkg::cmd_t   cmd,
    input  logic [31:0]       message_word,
    output logic [31:0]       digest_word
);

    localparam int unsigned NW = shabh_pkg::WORDS_PER_BLOCK;
    localparam int unsigned NH = shabh_pkg::HASH_WORDS;

    logic [31:0] w_reg    [NW];
    logic [31:0] w_next   [NW];
    logic [31:0] v_reg    [NH];
    logic [31:0] v_next   [NH];
    logic [31:0] cv_reg   [NH];
    logic [31:0] cv_next  [NH];
    logic [31:0] obuf_reg [NH];
    logic [31:0] obuf_next[NH];
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign digest_word = obuf_reg[0];

    // Schedule expansion from the rolling 16-word window.
    assign sched_new = shabh_pkg::sched_s1(w_reg[14]) + w_reg[9]
                     + shabh_pkg::sched_s0(w_reg[1]) + w_reg[0];

    // One compression round.
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + shabh_pkg::round_s1(v_reg[4]) + ch
               + shabh_pkg::ROUND_K[cmd.round_idx] + w_reg[0];
    assign t2  = shabh_pkg::round_s0(v_reg[0]) + maj;

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            w_next[i] = w_reg[i];
        end
        for (int i = 0; i < NH; i++)
        begin
            v_next[i]    = v_reg[i];
            cv_next[i]   = cv_reg[i];
            obuf_next[i] = obuf_reg[i];
        end

        // Schedule window shifts on each new word and each round.
        if (cmd.shift_in || cmd.round_en)
        begin
            for (int i = 0; i < NW - 1; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[NW - 1] = cmd.shift_in ? message_word : sched_new;
        end

        // Working variables.
        if (cmd.load_vars)
        begin
            for (int i = 0; i < NH; i++)
            begin
                v_next[i] = cmd.use_iv ? shabh_pkg::INIT_HASH[i] : cv_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end

        // Feed-forward add into the chaining words.
        if (cmd.final_add)
        begin
            for (int i = 0; i < NH; i++)
            begin
                cv_next[i] = (cmd.use_iv ? shabh_pkg::INIT_HASH[i] : cv_reg[i]) + v_reg[i];
            end
        end

        // Digest buffer: load on a final block, shift out one word per item.
        if (cmd.load_out)
        begin
            for (int i = 0; i < NH; i++)
            begin
                obuf_next[i] = cv_next[i];
            end
        end
        else if (cmd.out_shift)
        begin
            for (int i = 0; i < NH - 1; i++)
            begin
                obuf_next[i] = obuf_reg[i + 1];
            end
            obuf_next[NH - 1] = obuf_reg[NH - 1];
        end
    end

    // Chaining words start from the initial hash.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NH; i++)
            begin
                cv_reg[i] <= shabh_pkg::INIT_HASH[i];
            end
        end
        else
        begin
            for (int i = 0; i < NH; i++)
            begin
                cv_reg[i] <= cv_next[i];
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NW; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        for (int i = 0; i < NH; i++)
        begin
            v_reg[i]    <= v_next[i];
            obuf_reg[i] <= obuf_next[i];
        end
    end

endmodule

// ===== design/sha256_block_hasher.sv =====
// Top level of the SHA-256 block hasher: controller plus datapath.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid, in_ready  | message_word, start_message, end_message
//  output  | out_valid, out_ready| digest_word, word_index, last_word
//
// Words 1 to 15 of a block are only gathered; the 16th starts the 64 compression
// rounds (one round per cycle through the single round unit) and then the
// feed-forward step; no further words are taken until the block is done.
// Reset restores the initial hash and sets all control state to its idle values at once.
// The eight digest words drain from their own buffer while the next block is
// gathered; a further digest waits only if that buffer has not yet emptied.
module sha256_block_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] message_word,
    input  logic        start_message,
    input  logic        end_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    shabh_pkg::cmd_t cmd;

    // Sequencing.
    shabh_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_message (start_message),
        .end_message   (end_message),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .word_index    (word_index),
        .last_word     (last_word),
        .cmd           (cmd)
    );

    // Hashing datapath.
    shabh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_word (message_word),
        .digest_word  (digest_word)
    );

endmodule
